// ===== rtl/rti_pkg.sv =====
// Shared types, constants and micro-op table of the ray/triangle intersection core.
// No dependencies; every other file uses this package by scoped names.
package rti_pkg;

   localparam int COORD_WIDTH_DEF = 32;
   localparam int FIELD_W         = 32;
   localparam int EPS_W           = 16;
   localparam int BARY_W          = 17;
   localparam int MUL_DIGIT       = 16;
   localparam int QUOT_W          = 31;
   localparam int QCNT_W          = $clog2(QUOT_W + 1);
   localparam int STEP_W          = 5;
   localparam int FRAC_BITS       = 16;
   localparam int EPS_SHIFT       = 32;

   localparam logic [EPS_W-1:0]        EPS_RESET = 16'd1;
   localparam logic [BARY_W-1:0]       BARY_ONE  = 17'h10000;
   localparam logic [FIELD_W-1:0]      DIST_MAX  = 32'h7FFF_FFFF;
   localparam logic [STEP_W-1:0]       STEP_DOT_LAST = 5'd23;
   localparam logic [STEP_W-1:0]       STEP_DEPS     = 5'd24;

   localparam logic REQ_LOAD = 1'b0;
   localparam logic REQ_RAY  = 1'b1;

   typedef enum logic [4:0] {
      OPN_E1X, OPN_E1Y, OPN_E1Z, OPN_E2X, OPN_E2Y, OPN_E2Z,
      OPN_DX, OPN_DY, OPN_DZ, OPN_TX, OPN_TY, OPN_TZ,
      OPN_PX, OPN_PY, OPN_PZ, OPN_QX, OPN_QY, OPN_QZ,
      OPN_DET, OPN_EPS
   } opnd_type;

   typedef enum logic [3:0] {
      DST_NONE, DST_PX, DST_PY, DST_PZ, DST_QX, DST_QY, DST_QZ,
      DST_DET, DST_UN, DST_VN, DST_TN, DST_DEPS
   } dst_type;

   typedef enum logic [1:0] {DIV_U, DIV_V, DIV_T} div_sel_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_EDGE, ST_MSTART, ST_MWAIT, ST_FIX, ST_CHECK,
      ST_JUDGE, ST_TCHECK, ST_DSTART, ST_DWAIT, ST_DONE
   } state_type;

   typedef struct packed {
      opnd_type a;
      opnd_type b;
      logic     first;
      logic     sub;
      dst_type  dst;
   } uop_type;

   typedef struct packed {
      logic        req_ready;
      logic        edge_upd;
      logic        mul_start;
      uop_type     uop;
      logic        fix;
      logic        chk;
      logic        tchk;
      logic        div_start;
      div_sel_type div_sel;
      logic        rsp_load;
   } cmd_type;

   typedef struct packed {
      logic req_valid;
      logic req_is_ray;
      logic mul_done;
      logic div_done;
      logic miss;
      logic rsp_free;
   } stat_type;

   // pv = dir x e2, qv = tv x e1, then det, u, v, t numerators, then det * epsilon
   function automatic uop_type uop(input logic [STEP_W-1:0] step);
      uop_type r;
      unique case (step)
         5'd0:  r = '{OPN_DY, OPN_E2Z, 1'b1, 1'b0, DST_NONE};
         5'd1:  r = '{OPN_DZ, OPN_E2Y, 1'b0, 1'b1, DST_PX};
         5'd2:  r = '{OPN_DZ, OPN_E2X, 1'b1, 1'b0, DST_NONE};
         5'd3:  r = '{OPN_DX, OPN_E2Z, 1'b0, 1'b1, DST_PY};
         5'd4:  r = '{OPN_DX, OPN_E2Y, 1'b1, 1'b0, DST_NONE};
         5'd5:  r = '{OPN_DY, OPN_E2X, 1'b0, 1'b1, DST_PZ};
         5'd6:  r = '{OPN_TY, OPN_E1Z, 1'b1, 1'b0, DST_NONE};
         5'd7:  r = '{OPN_TZ, OPN_E1Y, 1'b0, 1'b1, DST_QX};
         5'd8:  r = '{OPN_TZ, OPN_E1X, 1'b1, 1'b0, DST_NONE};
         5'd9:  r = '{OPN_TX, OPN_E1Z, 1'b0, 1'b1, DST_QY};
         5'd10: r = '{OPN_TX, OPN_E1Y, 1'b1, 1'b0, DST_NONE};
         5'd11: r = '{OPN_TY, OPN_E1X, 1'b0, 1'b1, DST_QZ};
         5'd12: r = '{OPN_PX, OPN_E1X, 1'b1, 1'b0, DST_NONE};
         5'd13: r = '{OPN_PY, OPN_E1Y, 1'b0, 1'b0, DST_NONE};
         5'd14: r = '{OPN_PZ, OPN_E1Z, 1'b0, 1'b0, DST_DET};
         5'd15: r = '{OPN_PX, OPN_TX, 1'b1, 1'b0, DST_NONE};
         5'd16: r = '{OPN_PY, OPN_TY, 1'b0, 1'b0, DST_NONE};
         5'd17: r = '{OPN_PZ, OPN_TZ, 1'b0, 1'b0, DST_UN};
         5'd18: r = '{OPN_QX, OPN_DX, 1'b1, 1'b0, DST_NONE};
         5'd19: r = '{OPN_QY, OPN_DY, 1'b0, 1'b0, DST_NONE};
         5'd20: r = '{OPN_QZ, OPN_DZ, 1'b0, 1'b0, DST_VN};
         5'd21: r = '{OPN_QX, OPN_E2X, 1'b1, 1'b0, DST_NONE};
         5'd22: r = '{OPN_QY, OPN_E2Y, 1'b0, 1'b0, DST_NONE};
         5'd23: r = '{OPN_QZ, OPN_E2Z, 1'b0, 1'b0, DST_TN};
         5'd24: r = '{OPN_DET, OPN_EPS, 1'b1, 1'b0, DST_DEPS};
         default: r = '{OPN_DET, OPN_EPS, 1'b1, 1'b0, DST_NONE};
      endcase
      return r;
   endfunction

endpackage

// ===== rtl/rti_channels.sv =====
// Valid/ready channel interfaces of the intersection core: request, response, CSR write.
// Depends on rti_pkg for field widths.
interface rti_req_if;
   logic                                valid;
   logic                                ready;
   logic                                req_type;
   logic [1:0]                          vertex_index;
   logic signed [rti_pkg::FIELD_W-1:0]  coord_x;
   logic signed [rti_pkg::FIELD_W-1:0]  coord_y;
   logic signed [rti_pkg::FIELD_W-1:0]  coord_z;
   logic signed [rti_pkg::FIELD_W-1:0]  dir_x;
   logic signed [rti_pkg::FIELD_W-1:0]  dir_y;
   logic signed [rti_pkg::FIELD_W-1:0]  dir_z;
   logic                                accept_back_face;
   modport source (output valid, req_type, vertex_index, coord_x, coord_y, coord_z,
                   dir_x, dir_y, dir_z, accept_back_face, input ready);
   modport sink (input valid, req_type, vertex_index, coord_x, coord_y, coord_z,
                 dir_x, dir_y, dir_z, accept_back_face, output ready);
endinterface

interface rti_rsp_if;
   logic                                valid;
   logic                                ready;
   logic                                hit;
   logic signed [rti_pkg::FIELD_W-1:0]  dist_t;
   logic [rti_pkg::BARY_W-1:0]          bary_u;
   logic [rti_pkg::BARY_W-1:0]          bary_v;
   logic [rti_pkg::BARY_W-1:0]          bary_w;
   modport source (output valid, hit, dist_t, bary_u, bary_v, bary_w, input ready);
   modport sink (input valid, hit, dist_t, bary_u, bary_v, bary_w, output ready);
endinterface

interface rti_csr_if;
   logic                        valid;
   logic                        ready;
   logic [rti_pkg::EPS_W-1:0]   data;
   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface

// ===== rtl/ray_triangle_intersect_core.sv =====
// Ray/triangle intersection core: one stored triangle, Moller-Trumbore test per ray.
// Ray items use the shared digit-serial multiplier and the one-bit-per-cycle divider;
// one item at a time, the response register frees the input.
// Synchronous reset clears the triangle to zero, epsilon to one and drops any item.
// Depends on rti_pkg, rti_channels, rti_ctrl, rti_datapath.
module ray_triangle_intersect_core #(
   parameter int COORD_WIDTH = rti_pkg::COORD_WIDTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   rti_req_if.sink    req_chan,
   rti_rsp_if.source  rsp_chan,
   rti_csr_if.sink    csr_chan
);

   rti_pkg::cmd_type  cmd;
   rti_pkg::stat_type stat;

   rti_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .stat  (stat),
      .cmd   (cmd)
   );

   rti_datapath #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan),
      .cmd      (cmd),
      .stat     (stat)
   );

endmodule

// ===== rtl/rti_ctrl.sv =====
// Sequencer of the intersection core: walks the micro-op table and the three divisions.
// Depends on rti_pkg; drives the datapath through cmd_type, watches stat_type.
module rti_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  rti_pkg::stat_type  stat,
   output rti_pkg::cmd_type   cmd
);

   rti_pkg::state_type                state_ff, state_in;
   logic [rti_pkg::STEP_W-1:0]        step_ff, step_in;
   rti_pkg::div_sel_type              div_sel_ff, div_sel_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= rti_pkg::ST_IDLE;
         step_ff    <= '0;
         div_sel_ff <= rti_pkg::DIV_U;
      end else begin
         state_ff   <= state_in;
         step_ff    <= step_in;
         div_sel_ff <= div_sel_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      step_in    = step_ff;
      div_sel_in = div_sel_ff;
      unique case (state_ff)
         rti_pkg::ST_IDLE: begin
            if (stat.req_valid) begin
               if (stat.req_is_ray) begin
                  step_in  = '0;
                  state_in = rti_pkg::ST_MSTART;
               end else begin
                  state_in = rti_pkg::ST_EDGE;
               end
            end
         end
         rti_pkg::ST_EDGE:   state_in = rti_pkg::ST_IDLE;
         rti_pkg::ST_MSTART: state_in = rti_pkg::ST_MWAIT;
         rti_pkg::ST_MWAIT: begin
            if (stat.mul_done) begin
               if (step_ff == rti_pkg::STEP_DOT_LAST) begin
                  state_in = rti_pkg::ST_FIX;
               end else if (step_ff == rti_pkg::STEP_DEPS) begin
                  state_in = rti_pkg::ST_TCHECK;
               end else begin
                  step_in  = step_ff + 1'b1;
                  state_in = rti_pkg::ST_MSTART;
               end
            end
         end
         rti_pkg::ST_FIX:    state_in = rti_pkg::ST_CHECK;
         rti_pkg::ST_CHECK:  state_in = rti_pkg::ST_JUDGE;
         rti_pkg::ST_TCHECK: state_in = rti_pkg::ST_JUDGE;
         rti_pkg::ST_JUDGE: begin
            if (stat.miss) begin
               state_in = rti_pkg::ST_DONE;
            end else if (step_ff == rti_pkg::STEP_DOT_LAST) begin
               step_in  = rti_pkg::STEP_DEPS;
               state_in = rti_pkg::ST_MSTART;
            end else begin
               div_sel_in = rti_pkg::DIV_U;
               state_in   = rti_pkg::ST_DSTART;
            end
         end
         rti_pkg::ST_DSTART: state_in = rti_pkg::ST_DWAIT;
         rti_pkg::ST_DWAIT: begin
            if (stat.div_done) begin
               unique case (div_sel_ff)
                  rti_pkg::DIV_U: begin
                     div_sel_in = rti_pkg::DIV_V;
                     state_in   = rti_pkg::ST_DSTART;
                  end
                  rti_pkg::DIV_V: begin
                     div_sel_in = rti_pkg::DIV_T;
                     state_in   = rti_pkg::ST_DSTART;
                  end
                  default: state_in = rti_pkg::ST_DONE;
               endcase
            end
         end
         rti_pkg::ST_DONE: begin
            if (stat.rsp_free) begin
               state_in = rti_pkg::ST_IDLE;
            end
         end
         default: state_in = rti_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd           = '0;
      cmd.uop       = rti_pkg::uop(step_ff);
      cmd.div_sel   = div_sel_ff;
      unique case (state_ff)
         rti_pkg::ST_IDLE:   cmd.req_ready = 1'b1;
         rti_pkg::ST_EDGE:   cmd.edge_upd  = 1'b1;
         rti_pkg::ST_MSTART: cmd.mul_start = 1'b1;
         rti_pkg::ST_FIX:    cmd.fix       = 1'b1;
         rti_pkg::ST_CHECK:  cmd.chk       = 1'b1;
         rti_pkg::ST_TCHECK: cmd.tchk      = 1'b1;
         rti_pkg::ST_DSTART: cmd.div_start = 1'b1;
         rti_pkg::ST_DONE:   cmd.rsp_load  = stat.rsp_free;
         default: ;
      endcase
   end

   a_ray_runs: assert property (@(posedge clock) disable iff (reset)
      (state_ff == rti_pkg::ST_IDLE && stat.req_valid && stat.req_is_ray)
      |=> (state_ff == rti_pkg::ST_MSTART && step_ff == '0))
      else $error("ray item did not start the micro-op sequence");

   a_deps_after_check: assert property (@(posedge clock) disable iff (reset)
      (state_ff == rti_pkg::ST_TCHECK) |-> (step_ff == rti_pkg::STEP_DEPS))
      else $error("distance check outside the det*epsilon step");

   a_no_ready_busy: assert property (@(posedge clock) disable iff (reset)
      (stat.mul_done || stat.div_done) |-> !cmd.req_ready)
      else $error("input taken while arithmetic in flight");

endmodule

// ===== rtl/rti_datapath.sv =====
// Datapath of the intersection core: triangle store, shared digit-serial multiplier,
// restoring divider, checks and the response register. Depends on rti_pkg, rti_channels.
module rti_datapath #(
   parameter int COORD_WIDTH = rti_pkg::COORD_WIDTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   rti_req_if.sink            req_chan,
   rti_rsp_if.source          rsp_chan,
   rti_csr_if.sink            csr_chan,
   input  rti_pkg::cmd_type   cmd,
   output rti_pkg::stat_type  stat
);

   localparam int W   = COORD_WIDTH;
   localparam int EW  = W + 1;
   localparam int PVW = 2 * W + 3;
   localparam int SW  = 3 * W + 7;
   localparam int BW  = W + 1;
   localparam int D   = rti_pkg::MUL_DIGIT;
   localparam int NA  = (SW + D - 1) / D;
   localparam int NAW = NA * D;
   localparam int RW  = SW + BW;
   localparam int QW  = rti_pkg::QUOT_W;
   localparam int DVW = SW + QW;
   localparam int CW  = $clog2(NA + 1);
   localparam int FB  = rti_pkg::FRAC_BITS;

   logic signed [W-1:0]  coord [6];
   logic [rti_pkg::FIELD_W-1:0] raw [6];

   assign raw[0] = req_chan.coord_x;
   assign raw[1] = req_chan.coord_y;
   assign raw[2] = req_chan.coord_z;
   assign raw[3] = req_chan.dir_x;
   assign raw[4] = req_chan.dir_y;
   assign raw[5] = req_chan.dir_z;

   for (genvar g = 0; g < 6; g++) begin : g_coord
      if (W <= rti_pkg::FIELD_W) begin : g_narrow
         assign coord[g] = raw[g][W-1:0];
      end else begin : g_wide
         assign coord[g] = W'(raw[g]);
      end
   end

   logic [rti_pkg::EPS_W-1:0] eps_ff;
   logic signed [W-1:0]   vtx_ff [3][3];
   logic signed [EW-1:0]  e1_ff [3];
   logic signed [EW-1:0]  e2_ff [3];
   logic signed [W-1:0]   dir_ff [3];
   logic signed [EW-1:0]  tv_ff [3];
   logic                  abf_ff;
   logic signed [PVW-1:0] p_ff [3];
   logic signed [PVW-1:0] q_ff [3];
   logic signed [SW-1:0]  det_ff, un_ff, vn_ff, tn_ff;
   logic signed [RW-1:0]  deps_ff;
   logic [RW-1:0]         sum_ff;
   logic                  miss_ff, sat_ff;

   logic signed [BW-1:0]  b_ff;
   logic [NAW-1:0]        amag_ff;
   logic                  aneg_ff;
   logic signed [RW-1:0]  acc_ff, acc_in;
   logic [CW-1:0]         mcnt_ff;
   logic                  mul_busy_ff;

   logic [DVW-1:0]        rem_ff, rem_in, dsh_ff;
   logic [QW-1:0]         quo_ff, quo_in;
   logic [rti_pkg::QCNT_W-1:0] dcnt_ff;
   logic                  div_busy_ff;
   rti_pkg::div_sel_type  dsel_ff;
   logic [QW-1:0]         res_u_ff, res_v_ff, res_t_ff;

   logic                  rsp_valid_ff, hit_ff;
   logic [rti_pkg::FIELD_W-1:0] dist_ff;
   logic [rti_pkg::BARY_W-1:0]  bu_ff, bv_ff, bw_ff;

   logic take;
   assign take = req_chan.valid && req_chan.ready;
   assign req_chan.ready = cmd.req_ready;
   assign csr_chan.ready = 1'b1;

   // operand selection
   logic signed [SW-1:0] a_sel, a_abs;
   logic signed [BW-1:0] b_sel;

   always_comb begin
      case (cmd.uop.a)
         rti_pkg::OPN_E1X: a_sel = SW'(e1_ff[0]);
         rti_pkg::OPN_E1Y: a_sel = SW'(e1_ff[1]);
         rti_pkg::OPN_E1Z: a_sel = SW'(e1_ff[2]);
         rti_pkg::OPN_E2X: a_sel = SW'(e2_ff[0]);
         rti_pkg::OPN_E2Y: a_sel = SW'(e2_ff[1]);
         rti_pkg::OPN_E2Z: a_sel = SW'(e2_ff[2]);
         rti_pkg::OPN_DX:  a_sel = SW'(dir_ff[0]);
         rti_pkg::OPN_DY:  a_sel = SW'(dir_ff[1]);
         rti_pkg::OPN_DZ:  a_sel = SW'(dir_ff[2]);
         rti_pkg::OPN_TX:  a_sel = SW'(tv_ff[0]);
         rti_pkg::OPN_TY:  a_sel = SW'(tv_ff[1]);
         rti_pkg::OPN_TZ:  a_sel = SW'(tv_ff[2]);
         rti_pkg::OPN_PX:  a_sel = SW'(p_ff[0]);
         rti_pkg::OPN_PY:  a_sel = SW'(p_ff[1]);
         rti_pkg::OPN_PZ:  a_sel = SW'(p_ff[2]);
         rti_pkg::OPN_QX:  a_sel = SW'(q_ff[0]);
         rti_pkg::OPN_QY:  a_sel = SW'(q_ff[1]);
         rti_pkg::OPN_QZ:  a_sel = SW'(q_ff[2]);
         rti_pkg::OPN_DET: a_sel = det_ff;
         default:          a_sel = '0;
      endcase
      case (cmd.uop.b)
         rti_pkg::OPN_E1X: b_sel = e1_ff[0];
         rti_pkg::OPN_E1Y: b_sel = e1_ff[1];
         rti_pkg::OPN_E1Z: b_sel = e1_ff[2];
         rti_pkg::OPN_E2X: b_sel = e2_ff[0];
         rti_pkg::OPN_E2Y: b_sel = e2_ff[1];
         rti_pkg::OPN_E2Z: b_sel = e2_ff[2];
         rti_pkg::OPN_DX:  b_sel = BW'(dir_ff[0]);
         rti_pkg::OPN_DY:  b_sel = BW'(dir_ff[1]);
         rti_pkg::OPN_DZ:  b_sel = BW'(dir_ff[2]);
         rti_pkg::OPN_TX:  b_sel = tv_ff[0];
         rti_pkg::OPN_TY:  b_sel = tv_ff[1];
         rti_pkg::OPN_TZ:  b_sel = tv_ff[2];
         rti_pkg::OPN_EPS: b_sel = signed'(BW'(eps_ff));
         default:          b_sel = '0;
      endcase
      a_abs = a_sel[SW-1] ? -a_sel : a_sel;
   end

   // multiplier: one digit of |a| per cycle against the full b, most significant first
   logic [D-1:0]          digit;
   logic signed [BW+D:0]  pp;
   logic                  mul_last, neg;
   logic [RW-1:0]         base, addend, nsum;

   assign digit    = amag_ff[NAW-1 -: D];
   assign pp       = b_ff * $signed({1'b0, digit});
   assign acc_in   = (acc_ff <<< D) + RW'(pp);
   assign mul_last = mul_busy_ff && (mcnt_ff == '0);
   assign neg      = cmd.uop.sub ^ aneg_ff;
   assign base     = cmd.uop.first ? '0 : sum_ff;
   assign addend   = neg ? ~acc_ff : acc_ff;
   assign nsum     = base + addend + RW'(neg);

   // divider: one quotient bit per cycle
   logic                  ge, div_last;
   logic signed [SW-1:0]  dnum;

   assign ge       = rem_ff >= dsh_ff;
   assign rem_in   = ge ? rem_ff - dsh_ff : rem_ff;
   assign quo_in   = {quo_ff[QW-2:0], ge};
   assign div_last = div_busy_ff && (dcnt_ff == rti_pkg::QCNT_W'(1));

   always_comb begin
      case (cmd.div_sel)
         rti_pkg::DIV_U: dnum = un_ff;
         rti_pkg::DIV_V: dnum = vn_ff;
         default:        dnum = tn_ff;
      endcase
   end

   // checks
   logic signed [SW-1:0]  epsq;
   logic signed [SW:0]    uvsum;
   logic                  miss_c, miss_t, sat_c;
   logic signed [RW-1:0]  tn_sh;
   logic signed [SW+FB-1:0] tn_x, det_x;

   assign epsq   = signed'(SW'({eps_ff, {rti_pkg::EPS_SHIFT{1'b0}}}));
   assign uvsum  = (SW+1)'(un_ff) + (SW+1)'(vn_ff);
   assign miss_c = (det_ff == '0) || (det_ff < epsq) || un_ff[SW-1] || (det_ff < un_ff)
                   || vn_ff[SW-1] || ((SW+1)'(det_ff) < uvsum);
   assign tn_sh  = RW'(tn_ff) <<< FB;
   assign miss_t = tn_sh < deps_ff;
   assign tn_x   = (SW+FB)'(tn_ff);
   assign det_x  = (SW+FB)'(det_ff) <<< (FB - 1);
   assign sat_c  = tn_x >= det_x;

   logic [rti_pkg::BARY_W-1:0] u_c, v_c;
   assign u_c = res_u_ff[rti_pkg::BARY_W-1:0];
   assign v_c = res_v_ff[rti_pkg::BARY_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         eps_ff       <= rti_pkg::EPS_RESET;
         for (int i = 0; i < 3; i++) begin
            for (int k = 0; k < 3; k++) vtx_ff[i][k] <= '0;
            e1_ff[i] <= '0;
            e2_ff[i] <= '0;
         end
         mul_busy_ff  <= 1'b0;
         div_busy_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         miss_ff      <= 1'b0;
      end else begin
         if (csr_chan.valid) eps_ff <= csr_chan.data;

         if (take) begin
            if (req_chan.req_type == rti_pkg::REQ_LOAD) begin
               for (int i = 0; i < 3; i++) begin
                  if (req_chan.vertex_index == 2'(i)) begin
                     for (int k = 0; k < 3; k++) vtx_ff[i][k] <= coord[k];
                  end
               end
            end else begin
               for (int k = 0; k < 3; k++) begin
                  dir_ff[k] <= coord[3 + k];
                  tv_ff[k]  <= EW'(coord[k]) - EW'(vtx_ff[0][k]);
               end
               abf_ff  <= req_chan.accept_back_face;
               miss_ff <= 1'b0;
            end
         end

         if (cmd.edge_upd) begin
            for (int k = 0; k < 3; k++) begin
               e1_ff[k] <= EW'(vtx_ff[1][k]) - EW'(vtx_ff[0][k]);
               e2_ff[k] <= EW'(vtx_ff[2][k]) - EW'(vtx_ff[0][k]);
            end
         end

         if (cmd.mul_start) begin
            b_ff        <= b_sel;
            amag_ff     <= NAW'(unsigned'(a_abs));
            aneg_ff     <= a_sel[SW-1];
            acc_ff      <= '0;
            mcnt_ff     <= CW'(NA);
            mul_busy_ff <= 1'b1;
         end else if (mul_last) begin
            mul_busy_ff <= 1'b0;
            sum_ff      <= nsum;
            case (cmd.uop.dst)
               rti_pkg::DST_PX:   p_ff[0] <= nsum[PVW-1:0];
               rti_pkg::DST_PY:   p_ff[1] <= nsum[PVW-1:0];
               rti_pkg::DST_PZ:   p_ff[2] <= nsum[PVW-1:0];
               rti_pkg::DST_QX:   q_ff[0] <= nsum[PVW-1:0];
               rti_pkg::DST_QY:   q_ff[1] <= nsum[PVW-1:0];
               rti_pkg::DST_QZ:   q_ff[2] <= nsum[PVW-1:0];
               rti_pkg::DST_DET:  det_ff  <= nsum[SW-1:0];
               rti_pkg::DST_UN:   un_ff   <= nsum[SW-1:0];
               rti_pkg::DST_VN:   vn_ff   <= nsum[SW-1:0];
               rti_pkg::DST_TN:   tn_ff   <= nsum[SW-1:0];
               rti_pkg::DST_DEPS: deps_ff <= nsum;
               default: ;
            endcase
         end else if (mul_busy_ff) begin
            acc_ff  <= acc_in;
            amag_ff <= amag_ff << D;
            mcnt_ff <= mcnt_ff - 1'b1;
         end

         // two-sided test: flip a back face
         if (cmd.fix && abf_ff && det_ff[SW-1]) begin
            det_ff <= -det_ff;
            un_ff  <= -un_ff;
            vn_ff  <= -vn_ff;
            tn_ff  <= -tn_ff;
         end
         if (cmd.chk) miss_ff <= miss_c;
         if (cmd.tchk) begin
            miss_ff <= miss_t;
            sat_ff  <= sat_c;
         end

         if (cmd.div_start) begin
            rem_ff      <= DVW'(dnum) << FB;
            dsh_ff      <= DVW'(det_ff) << (QW - 1);
            quo_ff      <= '0;
            dcnt_ff     <= rti_pkg::QCNT_W'(QW);
            dsel_ff     <= cmd.div_sel;
            div_busy_ff <= 1'b1;
         end else if (div_busy_ff) begin
            rem_ff  <= rem_in;
            quo_ff  <= quo_in;
            dsh_ff  <= dsh_ff >> 1;
            dcnt_ff <= dcnt_ff - 1'b1;
            if (div_last) begin
               div_busy_ff <= 1'b0;
               case (dsel_ff)
                  rti_pkg::DIV_U: res_u_ff <= quo_in;
                  rti_pkg::DIV_V: res_v_ff <= quo_in;
                  default:        res_t_ff <= quo_in;
               endcase
            end
         end

         if (cmd.rsp_load) begin
            rsp_valid_ff <= 1'b1;
            hit_ff       <= !miss_ff;
            if (miss_ff) begin
               dist_ff <= '0;
               bu_ff   <= '0;
               bv_ff   <= '0;
               bw_ff   <= '0;
            end else begin
               dist_ff <= sat_ff ? rti_pkg::DIST_MAX : {1'b0, res_t_ff};
               bu_ff   <= u_c;
               bv_ff   <= v_c;
               bw_ff   <= rti_pkg::BARY_ONE - u_c - v_c;
            end
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_chan.valid  = rsp_valid_ff;
   assign rsp_chan.hit    = hit_ff;
   assign rsp_chan.dist_t = dist_ff;
   assign rsp_chan.bary_u = bu_ff;
   assign rsp_chan.bary_v = bv_ff;
   assign rsp_chan.bary_w = bw_ff;

   assign stat.req_valid  = req_chan.valid;
   assign stat.req_is_ray = req_chan.req_type == rti_pkg::REQ_RAY;
   assign stat.mul_done   = mul_last;
   assign stat.div_done   = div_last;
   assign stat.miss       = miss_ff;
   assign stat.rsp_free   = !rsp_valid_ff || rsp_chan.ready;

   a_mul_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.mul_start |-> !mul_busy_ff && !div_busy_ff)
      else $error("multiply started while a unit is busy");

   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |-> !div_busy_ff && !mul_busy_ff && !miss_ff)
      else $error("division started while busy or after a miss");

   a_rsp_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> (!rsp_valid_ff || rsp_chan.ready))
      else $error("response overwritten before it was taken");

endmodule

// ===== dv/ray_triangle_intersect_core_test.sv =====
// Self-checking testbench of ray_triangle_intersect_core: vertex loads, ray tests and
// epsilon writes over valid/ready channels, results checked against an exact predictor.
// Depends on rti_pkg, rti_channels and the core RTL.
module ray_triangle_intersect_core_test;
   timeunit 1ns;
   timeprecision 1ps;

   typedef logic signed [255:0] wide_type;
   localparam int ONE = 65536;

   typedef struct {
      logic                               kind;
      logic [1:0]                         vidx;
      logic signed [rti_pkg::FIELD_W-1:0] org [3];
      logic signed [rti_pkg::FIELD_W-1:0] dir [3];
      logic                               two_sided;
   } probe_type;

   typedef struct packed {
      logic                               hit;
      logic signed [rti_pkg::FIELD_W-1:0] dist_t;
      logic [rti_pkg::BARY_W-1:0]         u;
      logic [rti_pkg::BARY_W-1:0]         v;
      logic [rti_pkg::BARY_W-1:0]         w;
   } hit_rec_type;

   class intersect_scoreboard;
      logic signed [rti_pkg::FIELD_W-1:0] vert [9];
      logic [rti_pkg::EPS_W-1:0]          eps;
      hit_rec_type                        pending [$];
      int                                 errors;

      function new();
         foreach (vert[i]) vert[i] = '0;
         eps = rti_pkg::EPS_RESET;
         errors = 0;
      endfunction

      function void set_eps(logic [rti_pkg::EPS_W-1:0] val);
         eps = val;
      endfunction

      function wide_type ratio(wide_type num, wide_type den);
         logic [255:0] q;
         q = (num <<< rti_pkg::FRAC_BITS) / den;
         return (q > 256'h7FFF_FFFF) ? wide_type'(rti_pkg::DIST_MAX) : wide_type'(q);
      endfunction

      function void cross3(input wide_type a [3], input wide_type b [3],
                           output wide_type r [3]);
         r[0] = a[1] * b[2] - a[2] * b[1];
         r[1] = a[2] * b[0] - a[0] * b[2];
         r[2] = a[0] * b[1] - a[1] * b[0];
      endfunction

      function wide_type dot3(input wide_type a [3], input wide_type b [3]);
         return a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
      endfunction

      function void note_request(probe_type p);
         wide_type e1 [3], e2 [3], d [3], tv [3], pv [3], qv [3];
         wide_type det, un, vn, tn, u, v, t;
         hit_rec_type r;
         if (p.kind == rti_pkg::REQ_LOAD) begin
            if (p.vidx < 3)
               for (int k = 0; k < 3; k++) vert[p.vidx * 3 + k] = p.org[k];
            return;
         end
         for (int k = 0; k < 3; k++) begin
            e1[k] = wide_type'(vert[3 + k]) - wide_type'(vert[k]);
            e2[k] = wide_type'(vert[6 + k]) - wide_type'(vert[k]);
            d[k]  = wide_type'(p.dir[k]);
            tv[k] = wide_type'(p.org[k]) - wide_type'(vert[k]);
         end
         cross3(d, e2, pv);
         det = dot3(e1, pv);
         cross3(tv, e1, qv);
         un = dot3(tv, pv);
         vn = dot3(d, qv);
         tn = dot3(e2, qv);
         if (p.two_sided && det < 0) begin
            det = -det; un = -un; vn = -vn; tn = -tn;
         end
         r = '{1'b0, '0, '0, '0, '0};
         if (det != 0 && det >= (wide_type'(eps) <<< rti_pkg::EPS_SHIFT) && un >= 0 &&
             un <= det && vn >= 0 && un + vn <= det && tn * ONE >= det * wide_type'(eps)) begin
            u = ratio(un, det);
            v = ratio(vn, det);
            t = (tn < 0) ? wide_type'(0) : ratio(tn, det);
            r.hit = 1'b1;
            r.dist_t = t[rti_pkg::FIELD_W-1:0];
            r.u = u[rti_pkg::BARY_W-1:0];
            r.v = v[rti_pkg::BARY_W-1:0];
            r.w = rti_pkg::BARY_ONE - u[rti_pkg::BARY_W-1:0] - v[rti_pkg::BARY_W-1:0];
         end
         pending.push_back(r);
      endfunction

      function void check_result(hit_rec_type got);
         hit_rec_type exp;
         if (pending.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result hit=%0d t=%h", got.hit, got.dist_t);
            return;
         end
         exp = pending.pop_front();
         if (got !== exp) begin
            errors++;
            if (errors <= 10)
               $display("mismatch: exp hit=%0d t=%h u=%h v=%h w=%h, got hit=%0d t=%h u=%h v=%h w=%h",
                        exp.hit, exp.dist_t, exp.u, exp.v, exp.w,
                        got.hit, got.dist_t, got.u, got.v, got.w);
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   rti_req_if req_chan ();
   rti_rsp_if rsp_chan ();
   rti_csr_if csr_chan ();

   ray_triangle_intersect_core DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source),
      .csr_chan (csr_chan.sink)
   );

   intersect_scoreboard board = new();
   bit  idle_off = 1'b0;
   bit  hold_rsp = 1'b0;
   int  quiet_cycles = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int pick_gap();
      int r;
      if (idle_off) return 0;
      r = int'($urandom_range(0, 99));
      if (r < 60) return 0;
      if (r < 92) return int'($urandom_range(1, 3));
      return int'($urandom_range(10, 60));
   endfunction

   always @(posedge clock) begin
      probe_type p;
      hit_rec_type h;
      if (req_chan.valid && req_chan.ready) begin
         p.kind = req_chan.req_type;
         p.vidx = req_chan.vertex_index;
         p.org = '{req_chan.coord_x, req_chan.coord_y, req_chan.coord_z};
         p.dir = '{req_chan.dir_x, req_chan.dir_y, req_chan.dir_z};
         p.two_sided = req_chan.accept_back_face;
         board.note_request(p);
      end
      if (rsp_chan.valid && rsp_chan.ready) begin
         h = '{rsp_chan.hit, rsp_chan.dist_t, rsp_chan.bary_u, rsp_chan.bary_v, rsp_chan.bary_w};
         board.check_result(h);
      end
      if (!reset && ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready) ||
                     (csr_chan.valid && csr_chan.ready)))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      int g;
      rsp_chan.ready = 1'b0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            rsp_chan.ready <= 1'b0;
            repeat (1500) @(posedge clock);
            hold_rsp = 1'b0;
         end
         g = pick_gap();
         if (g > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (g) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
      end
   end

   initial begin
      wait (quiet_cycles >= 30000);
      $display("ray_triangle_intersect_core_test: done, errors");
      $finish;
   end

   task automatic send(probe_type p);
      req_chan.valid            <= 1'b1;
      req_chan.req_type         <= p.kind;
      req_chan.vertex_index     <= p.vidx;
      req_chan.coord_x          <= p.org[0];
      req_chan.coord_y          <= p.org[1];
      req_chan.coord_z          <= p.org[2];
      req_chan.dir_x            <= p.dir[0];
      req_chan.dir_y            <= p.dir[1];
      req_chan.dir_z            <= p.dir[2];
      req_chan.accept_back_face <= p.two_sided;
      do @(posedge clock); while (!req_chan.ready);
      begin
         int g;
         g = pick_gap();
         if (g > 0) begin
            req_chan.valid <= 1'b0;
            repeat (g) @(posedge clock);
         end
      end
   endtask

   task automatic load(logic [1:0] idx, int x, int y, int z);
      probe_type p;
      p = '{rti_pkg::REQ_LOAD, idx, '{x, y, z}, '{$urandom, $urandom, $urandom},
            1'($urandom_range(0, 1))};
      send(p);
   endtask

   task automatic ray(int ox, int oy, int oz, int dx, int dy, int dz, logic two);
      probe_type p;
      p = '{rti_pkg::REQ_RAY, 2'($urandom_range(0, 3)), '{ox, oy, oz}, '{dx, dy, dz}, two};
      send(p);
   endtask

   task automatic write_eps(logic [rti_pkg::EPS_W-1:0] val);
      req_chan.valid <= 1'b0;
      @(posedge clock);
      wait (board.pending.size() == 0);
      repeat (8) @(posedge clock);
      csr_chan.valid <= 1'b1;
      csr_chan.data  <= val;
      do @(posedge clock); while (!csr_chan.ready);
      board.set_eps(val);
      csr_chan.valid <= 1'b0;
   endtask

   task automatic unit_triangle();
      load(2'd0, 0, 0, 0);
      load(2'd1, ONE, 0, 0);
      load(2'd2, 0, ONE, 0);
   endtask

   task automatic random_item();
      longint v [9], o [3], a, b;
      int r;
      r = int'($urandom_range(0, 99));
      if (r < 8) begin
         for (int k = 0; k < 3; k++)
            load(2'($urandom_range(0, 3)),
                 $urandom_range(0, 1) ? int'($urandom)
                                      : int'($urandom_range(0, 1 << 19)) - (1 << 18),
                 int'($urandom_range(0, 524288)) - 262144,
                 int'($urandom_range(0, 524288)) - 262144);
      end else if (r < 12) begin
         load(2'($urandom_range(0, 3)), int'($urandom), int'($urandom), int'($urandom));
      end else if (r < 22) begin
         ray(int'($urandom), int'($urandom), int'($urandom), int'($urandom), int'($urandom),
             int'($urandom), 1'($urandom_range(0, 1)));
      end else begin
         for (int k = 0; k < 9; k++) v[k] = board.vert[k];
         for (int k = 0; k < 3; k++) o[k] = longint'($urandom_range(0, 1 << 20)) - (1 << 19);
         a = $urandom_range(0, 256);
         b = $urandom_range(0, 256 - a);
         if (r < 30) begin
            a = $urandom_range(0, 300);
            b = $urandom_range(0, 300);
         end
         ray(int'(o[0]), int'(o[1]), int'(o[2]),
             int'(v[0] + (((v[3] - v[0]) * a + (v[6] - v[0]) * b) >>> 8) - o[0]),
             int'(v[1] + (((v[4] - v[1]) * a + (v[7] - v[1]) * b) >>> 8) - o[1]),
             int'(v[2] + (((v[5] - v[2]) * a + (v[8] - v[2]) * b) >>> 8) - o[2]),
             1'($urandom_range(0, 1)));
      end
   endtask

   initial begin
      logic [rti_pkg::EPS_W-1:0] eps_plan [5];
      req_chan.valid = 1'b0;
      req_chan.req_type = rti_pkg::REQ_LOAD;
      req_chan.vertex_index = '0;
      req_chan.coord_x = '0;
      req_chan.coord_y = '0;
      req_chan.coord_z = '0;
      req_chan.dir_x = '0;
      req_chan.dir_y = '0;
      req_chan.dir_z = '0;
      req_chan.accept_back_face = 1'b0;
      csr_chan.valid = 1'b0;
      csr_chan.data = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      ray(ONE / 4, ONE / 4, ONE, 0, 0, -ONE, 1'b0);
      unit_triangle();
      ray(ONE / 4, ONE / 4, ONE, 0, 0, -ONE, 1'b0);
      ray(ONE / 4, ONE / 4, -ONE, 0, 0, ONE, 1'b0);
      ray(ONE / 4, ONE / 4, -ONE, 0, 0, ONE, 1'b1);
      ray(0, ONE / 2, ONE, 0, 0, -ONE, 1'b1);
      ray(ONE / 2, ONE / 2, ONE, 0, 0, -ONE, 1'b1);
      ray(0, 0, ONE, 0, 0, -ONE, 1'b0);
      ray(ONE, ONE, ONE, 0, 0, -ONE, 1'b1);
      ray(ONE / 4, ONE / 4, -ONE, 0, 0, -ONE, 1'b1);
      ray(ONE / 4, ONE / 4, 0, 0, 0, -ONE, 1'b1);
      ray(ONE / 4, ONE / 4, ONE, ONE, 0, 0, 1'b1);
      ray(ONE / 4, ONE / 4, ONE, 0, 0, -1, 1'b1);
      ray(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
          32'h8000_0000, 1'b1);
      load(2'd3, ONE, ONE, ONE);
      ray(ONE / 4, ONE / 4, ONE, 0, 0, -ONE, 1'b0);
      load(2'd0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      load(2'd1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
      load(2'd2, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      ray(0, 0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
      ray(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
          32'h7FFF_FFFF, 1'b0);

      eps_plan = '{16'd0, 16'hFFFF, 16'd1, rti_pkg::EPS_W'($urandom_range(0, 4096)),
                   rti_pkg::EPS_W'($urandom)};
      foreach (eps_plan[ph]) begin
         write_eps(eps_plan[ph]);
         unit_triangle();
         ray(ONE / 4, ONE / 4, ONE, ONE, 0, 0, 1'b1);
         ray(ONE / 4, ONE / 4, ONE, 0, 0, -ONE, 1'b1);
         if (ph == 1) hold_rsp = 1'b1;
         idle_off = (ph == 2);
         repeat (215) random_item();
         idle_off = 1'b0;
      end

      req_chan.valid <= 1'b0;
      @(posedge clock);
      wait (board.pending.size() == 0);
      repeat (300) @(posedge clock);
      if (board.errors == 0 && board.pending.size() == 0)
         $display("ray_triangle_intersect_core_test: done, clean");
      else
         $display("ray_triangle_intersect_core_test: done, errors");
      $finish;
   end
endmodule
